>>> rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants for the thread slot scheduler
// Operation, status and slot state codes, the transaction structs and the
// write command that passes from the sequencer to the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int ThreadSlots = 32;
  localparam int SlotW       = $clog2(ThreadSlots);

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_WAKE    = 3'd3,
    OP_YIELD   = 3'd4,
    OP_SETRUN  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_ALLOC = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_DEADLOCK  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_RUNNABLE = 2'd0,
    SLOT_ACTIVE   = 2'd1,
    SLOT_BLOCKED  = 2'd2
  } slot_st_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ALLOC,
    SEQ_PASS
  } seq_state_e;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] target_thread;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] chosen_thread;
    logic       switched;
    logic [4:0] running_now;
  } result_t;

  typedef struct packed {
    logic             mask_set;
    logic             mask_clr;
    logic             state_we;
    slot_st_e         state_val;
    logic [SlotW-1:0] wr_idx;
    logic             run_we;
    logic [SlotW-1:0] run_val;
  } wr_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/rrts_slot_store.sv
// ----------------------------------------------------------------------------
// rrts_slot_store: slot table of the thread slot scheduler
// Holds the allocated mask, the per-slot run state and the running slot, with
// one read index and one write command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_slot_store (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire rrts_pkg::wr_cmd_t        wr_i,
  input  wire logic [rrts_pkg::SlotW-1:0] rd_idx_i,
  output logic                          rd_taken_o,
  output logic                          rd_runnable_o,
  output logic [rrts_pkg::SlotW-1:0]    running_o
);

  logic [rrts_pkg::ThreadSlots-1:0] mask_q;
  logic [rrts_pkg::SlotW-1:0]       run_q;
  rrts_pkg::slot_st_e               state_q [rrts_pkg::ThreadSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      run_q  <= '0;
    end else begin
      if (wr_i.mask_set) begin
        mask_q[wr_i.wr_idx] <= 1'b1;
      end else if (wr_i.mask_clr) begin
        mask_q[wr_i.wr_idx] <= 1'b0;
      end
      if (wr_i.run_we) begin
        run_q <= wr_i.run_val;
      end
    end
  end

  // run state is only read behind the allocated bit, so no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.state_we) begin
      state_q[wr_i.wr_idx] <= wr_i.state_val;
    end
  end

  assign rd_taken_o    = mask_q[rd_idx_i];
  assign rd_runnable_o = (state_q[rd_idx_i] == rrts_pkg::SLOT_RUNNABLE);
  assign running_o     = run_q;

endmodule

`default_nettype wire

>>> rtl/core/rrts_seq.sv
// ----------------------------------------------------------------------------
// rrts_seq: sequencer of the thread slot scheduler
// Decodes a transaction, steps one slot index per cycle through an allocate
// scan or a round robin pass, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_seq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire rrts_pkg::req_t             req_i,
  output logic                            busy_o,
  output rrts_pkg::wr_cmd_t               wr_o,
  output logic [rrts_pkg::SlotW-1:0]      rd_idx_o,
  input  wire logic                       rd_taken_i,
  input  wire logic                       rd_runnable_i,
  input  wire logic [rrts_pkg::SlotW-1:0] running_i,
  output logic                            res_valid_o,
  output rrts_pkg::result_t               res_o
);

  localparam logic [rrts_pkg::SlotW-1:0] LastIdx =
    rrts_pkg::SlotW'(rrts_pkg::ThreadSlots - 1);

  rrts_pkg::seq_state_e       state_q, state_d;
  logic [rrts_pkg::SlotW-1:0] idx_q, idx_d;
  logic [rrts_pkg::SlotW-1:0] cnt_q, cnt_d;
  logic                       res_vld_q, res_vld_d;
  rrts_pkg::result_t          res_q, res_d;
  rrts_pkg::op_e              op;
  logic [rrts_pkg::SlotW-1:0] inc_src;
  logic [rrts_pkg::SlotW-1:0] inc_res;
  logic                       hit;

  assign op = rrts_pkg::op_e'(req_i.op);

  // shared index stepper: round robin successor of the running slot or scan index
  assign inc_src = (state_q == rrts_pkg::SEQ_IDLE) ? running_i : idx_q;
  assign inc_res = (inc_src == LastIdx) ? '0 : inc_src + 1'b1;

  assign hit = rd_taken_i && rd_runnable_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrts_pkg::SEQ_IDLE: begin
        if (start_i) begin
          unique case (op)
            rrts_pkg::OP_ALLOC: state_d = rrts_pkg::SEQ_ALLOC;
            rrts_pkg::OP_BLOCK,
            rrts_pkg::OP_YIELD: begin
              if (rd_taken_i) state_d = rrts_pkg::SEQ_PASS;
            end
            default: state_d = rrts_pkg::SEQ_IDLE;
          endcase
        end
      end
      rrts_pkg::SEQ_ALLOC: begin
        if (!rd_taken_i || idx_q == LastIdx) state_d = rrts_pkg::SEQ_IDLE;
      end
      rrts_pkg::SEQ_PASS: begin
        if (hit || cnt_q == LastIdx) state_d = rrts_pkg::SEQ_IDLE;
      end
      default: state_d = rrts_pkg::SEQ_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    wr_o                = '0;
    wr_o.state_val      = rrts_pkg::SLOT_RUNNABLE;
    rd_idx_o            = idx_q;
    idx_d               = idx_q;
    cnt_d               = cnt_q;
    res_vld_d           = 1'b0;
    res_d               = res_q;
    res_d.status        = rrts_pkg::STATUS_OK;
    res_d.chosen_thread = '0;
    res_d.switched      = 1'b0;
    res_d.running_now   = running_i;
    unique case (state_q)
      rrts_pkg::SEQ_IDLE: begin
        rd_idx_o = (op == rrts_pkg::OP_YIELD) ? running_i : req_i.target_thread;
        wr_o.wr_idx = rd_idx_o;
        if (start_i) begin
          unique case (op)
            rrts_pkg::OP_ALLOC: begin
              idx_d = '0;
            end
            rrts_pkg::OP_RELEASE: begin
              res_vld_d = 1'b1;
              if (rd_taken_i) wr_o.mask_clr = 1'b1;
              else res_d.status = rrts_pkg::STATUS_NOT_ALLOC;
            end
            rrts_pkg::OP_WAKE: begin
              res_vld_d = 1'b1;
              if (rd_taken_i) wr_o.state_we = 1'b1;
              else res_d.status = rrts_pkg::STATUS_NOT_ALLOC;
            end
            rrts_pkg::OP_BLOCK,
            rrts_pkg::OP_YIELD: begin
              if (rd_taken_i) begin
                wr_o.state_we  = 1'b1;
                wr_o.state_val = (op == rrts_pkg::OP_BLOCK) ? rrts_pkg::SLOT_BLOCKED
                                                             : rrts_pkg::SLOT_RUNNABLE;
                idx_d = inc_res;
                cnt_d = '0;
              end else begin
                res_vld_d     = 1'b1;
                res_d.status  = rrts_pkg::STATUS_NOT_ALLOC;
              end
            end
            rrts_pkg::OP_SETRUN: begin
              res_vld_d         = 1'b1;
              wr_o.run_we       = 1'b1;
              wr_o.run_val      = req_i.target_thread;
              res_d.running_now = req_i.target_thread;
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      rrts_pkg::SEQ_ALLOC: begin
        wr_o.wr_idx = idx_q;
        if (!rd_taken_i) begin
          wr_o.mask_set       = 1'b1;
          wr_o.state_we       = 1'b1;
          res_vld_d           = 1'b1;
          res_d.chosen_thread = idx_q;
        end else if (idx_q == LastIdx) begin
          res_vld_d    = 1'b1;
          res_d.status = rrts_pkg::STATUS_FULL;
        end else begin
          idx_d = inc_res;
        end
      end
      rrts_pkg::SEQ_PASS: begin
        wr_o.wr_idx = idx_q;
        if (hit) begin
          wr_o.state_we       = 1'b1;
          wr_o.state_val      = rrts_pkg::SLOT_ACTIVE;
          wr_o.run_we         = 1'b1;
          wr_o.run_val        = idx_q;
          res_vld_d           = 1'b1;
          res_d.chosen_thread = idx_q;
          res_d.switched      = 1'b1;
          res_d.running_now   = idx_q;
        end else if (cnt_q == LastIdx) begin
          res_vld_d    = 1'b1;
          res_d.status = rrts_pkg::STATUS_DEADLOCK;
        end else begin
          idx_d = inc_res;
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        res_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrts_pkg::SEQ_IDLE;
      res_vld_q <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_d) begin
      res_q <= res_d;
    end
  end

  assign busy_o      = (state_q != rrts_pkg::SEQ_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> rtl/core/round_robin_thread_slot_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_slot_scheduler: round robin scheduler over 32 thread slots
// Command in on start/busy, one result per command on a one-cycle strobe.
//
// A command (op, target slot) is taken on a clock edge with start high and
// busy low. Each command gives exactly one result on result_o, marked by
// result_valid_o for a single cycle; the receiver cannot hold it off.
// Release, wake, set-running, failed block/yield and unused ops finish at
// once: the result shows in the cycle after the command and the next
// command can be taken in that same cycle.
// Allocate scans slots from the lowest, one per cycle, and takes the first
// free one; a full table gives a full status. Block and yield write the slot
// state, then run a pass that tests one slot per cycle from the slot after
// the running one, round to the running slot itself; if none is allocated
// and runnable the status is deadlock. No new command is taken while a scan
// or pass runs, as it holds the single slot index stepper and the one-slot
// read port of the table.
// Reset clears the allocated mask and the running slot and idles the
// sequencer; slot run states need no clearing as they are read only for
// allocated slots.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_slot_scheduler (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire rrts_pkg::req_t    req_i,
  output logic                   busy,
  output logic                   result_valid_o,
  output rrts_pkg::result_t      result_o
);

  rrts_pkg::wr_cmd_t          wr_cmd;
  logic [rrts_pkg::SlotW-1:0] rd_idx;
  logic                       rd_taken;
  logic                       rd_runnable;
  logic [rrts_pkg::SlotW-1:0] running;

  rrts_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_i         (req_i),
    .busy_o        (busy),
    .wr_o          (wr_cmd),
    .rd_idx_o      (rd_idx),
    .rd_taken_i    (rd_taken),
    .rd_runnable_i (rd_runnable),
    .running_i     (running),
    .res_valid_o   (result_valid_o),
    .res_o         (result_o)
  );

  rrts_slot_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (wr_cmd),
    .rd_idx_i      (rd_idx),
    .rd_taken_o    (rd_taken),
    .rd_runnable_o (rd_runnable),
    .running_o     (running)
  );

endmodule

`default_nettype wire

>>> test/tb_round_robin_thread_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_thread_slot_scheduler: self-checking bench for the slot scheduler
// Commands go in over start/busy. A behavioural copy of the slot table predicts
// every result; each strobe is checked field by field against it, or against a
// typed-in result for fixed directed rows. A short directed table runs first;
// random fill, scheduling, drain and noise phases follow, with random sender gaps.
// ----------------------------------------------------------------------------

module tb_round_robin_thread_slot_scheduler;
  import rrts_pkg::*;

  localparam int          RandItems  = 1400;
  localparam int          StallLimit = 2000;
  localparam int          TailCycles = 40;
  localparam int          DirRows    = 25;
  localparam logic [2:0]  OpSpare6   = 3'd6;
  localparam logic [2:0]  OpSpare7   = 3'd7;

  typedef enum int {MIX_FILL, MIX_SCHED, MIX_DRAIN, MIX_NOISE} traffic_e;

  typedef struct {
    req_t    req;
    bit      fixed;
    result_t res;
  } dir_row_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  req_t    req_i  = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  // Typed-in expectation travelling alongside the command it belongs to
  bit      fixed_valid  = 1'b0;
  result_t fixed_result = '0;

  // Predicted copy of the slot table
  logic [ThreadSlots-1:0] slot_alloc   = '0;
  slot_st_e               slot_run_st [ThreadSlots];
  logic [4:0]             running_slot = '0;

  result_t                expected_results [$];
  logic [ThreadSlots-1:0] mask_view    = '0;
  int unsigned            n_issued     = 0;
  int unsigned            n_returned   = 0;
  int unsigned            idle_cycles  = 0;
  int unsigned            fail_count   = 0;

  dir_row_t               dir_table [DirRows];

  round_robin_thread_slot_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one command to the predicted table and return the result it gives
  function automatic result_t schedule_step(req_t cmd);
    result_t    res;
    logic [4:0] slot;
    logic [4:0] idx;
    logic [4:0] pick;
    bit         found;
    res        = '0;
    res.status = STATUS_OK;
    found      = 1'b0;
    pick       = '0;
    case (cmd.op)
      OP_ALLOC: begin
        res.status = STATUS_FULL;
        for (int i = 0; i < ThreadSlots; i++) begin
          if (!found && !slot_alloc[i]) begin
            found                  = 1'b1;
            slot_alloc[i]          = 1'b1;
            slot_run_st[i]         = SLOT_RUNNABLE;
            res.chosen_thread      = 5'(i);
            res.status             = STATUS_OK;
          end
        end
      end
      OP_RELEASE: begin
        if (!slot_alloc[cmd.target_thread]) res.status = STATUS_NOT_ALLOC;
        else slot_alloc[cmd.target_thread] = 1'b0;
      end
      OP_BLOCK, OP_YIELD: begin
        slot = (cmd.op == OP_BLOCK) ? cmd.target_thread : running_slot;
        if (!slot_alloc[slot]) begin
          res.status = STATUS_NOT_ALLOC;
        end else begin
          slot_run_st[slot] = (cmd.op == OP_BLOCK) ? SLOT_BLOCKED : SLOT_RUNNABLE;
          // scan from the slot after the running one, ending on the running slot
          for (int i = 1; i <= ThreadSlots; i++) begin
            idx = running_slot + 5'(i);
            if (!found && slot_alloc[idx] && slot_run_st[idx] == SLOT_RUNNABLE) begin
              found = 1'b1;
              pick  = idx;
            end
          end
          if (found) begin
            running_slot      = pick;
            slot_run_st[pick] = SLOT_ACTIVE;
            res.chosen_thread = pick;
            res.switched      = 1'b1;
          end else begin
            res.status = STATUS_DEADLOCK;
          end
        end
      end
      OP_WAKE: begin
        if (!slot_alloc[cmd.target_thread]) res.status = STATUS_NOT_ALLOC;
        else slot_run_st[cmd.target_thread] = SLOT_RUNNABLE;
      end
      OP_SETRUN: running_slot = cmd.target_thread;
      default: ;
    endcase
    res.running_now = running_slot;
    return res;
  endfunction

  function automatic void flag_mismatch(string field, int unsigned exp_v, int unsigned got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    fail_count++;
  endfunction

  // Results and accepted commands are both sampled on the rising edge
  always @(posedge clk_i) begin : monitor
    result_t exp_res;
    result_t pred;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %p",
                   $time, result_o);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (result_o.status !== exp_res.status)
            flag_mismatch("status", exp_res.status, result_o.status);
          if (result_o.chosen_thread !== exp_res.chosen_thread)
            flag_mismatch("chosen_thread", exp_res.chosen_thread, result_o.chosen_thread);
          if (result_o.switched !== exp_res.switched)
            flag_mismatch("switched", exp_res.switched, result_o.switched);
          if (result_o.running_now !== exp_res.running_now)
            flag_mismatch("running_now", exp_res.running_now, result_o.running_now);
        end
        n_returned <= n_returned + 1;
      end
      if (start && !busy) begin
        pred = schedule_step(req_i);
        expected_results.push_back(fixed_valid ? fixed_result : pred);
        n_issued <= n_issued + 1;
      end
      mask_view   <= slot_alloc;
      idle_cycles <= (result_valid_o || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("round_robin_thread_slot_scheduler test failed");
    $finish;
  end

  // Hold start until the block takes the transaction
  task automatic issue(req_t cmd, bit fixed, result_t res);
    start        <= 1'b1;
    req_i        <= cmd;
    fixed_valid  <= fixed;
    fixed_result <= res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (n_issued != n_returned);
  endtask

  function automatic dir_row_t cmd_row(logic [2:0] op, logic [4:0] tgt, bit fixed,
                                       status_e st, logic [4:0] chosen, logic sw,
                                       logic [4:0] run);
    dir_row_t row;
    row.req.op            = op;
    row.req.target_thread = tgt;
    row.fixed             = fixed;
    row.res.status        = st;
    row.res.chosen_thread = chosen;
    row.res.switched      = sw;
    row.res.running_now   = run;
    return row;
  endfunction

  // Mostly an allocated slot, so that commands get past the allocation check
  function automatic logic [4:0] pick_slot();
    logic [4:0] slot;
    slot = 5'($urandom_range(0, ThreadSlots - 1));
    if (mask_view != '0 && $urandom_range(0, 99) < 85)
      for (int i = 0; i < ThreadSlots && !mask_view[slot]; i++) slot = slot + 5'd1;
    return slot;
  endfunction

  function automatic logic [2:0] choose_op(traffic_e kind);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (kind)
      MIX_FILL:  return OP_ALLOC;
      MIX_SCHED: begin
        if (roll < 30) return OP_BLOCK;
        if (roll < 55) return OP_WAKE;
        if (roll < 80) return OP_YIELD;
        if (roll < 85) return OP_SETRUN;
        if (roll < 90) return OP_RELEASE;
        return OP_ALLOC;
      end
      MIX_DRAIN: begin
        if (roll < 60) return OP_RELEASE;
        if (roll < 70) return OP_ALLOC;
        if (roll < 80) return OP_BLOCK;
        if (roll < 90) return OP_WAKE;
        if (roll < 95) return OP_YIELD;
        return OP_SETRUN;
      end
      default:   return 3'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_no;
    int unsigned phase_len;
    traffic_e    kind;
    bit          gaps_on;
    req_t        cmd;

    foreach (slot_run_st[i]) slot_run_st[i] = SLOT_RUNNABLE;

    // Empty table, running slot 0: refusals, set-running, allocates, spare ops
    dir_table[0]  = cmd_row(OP_YIELD,   5'd0,  1, STATUS_NOT_ALLOC, 5'd0, 1'b0, 5'd0);
    dir_table[1]  = cmd_row(OP_RELEASE, 5'd31, 1, STATUS_NOT_ALLOC, 5'd0, 1'b0, 5'd0);
    dir_table[2]  = cmd_row(OP_BLOCK,   5'd0,  1, STATUS_NOT_ALLOC, 5'd0, 1'b0, 5'd0);
    dir_table[3]  = cmd_row(OP_WAKE,    5'd16, 1, STATUS_NOT_ALLOC, 5'd0, 1'b0, 5'd0);
    dir_table[4]  = cmd_row(OP_SETRUN,  5'd31, 1, STATUS_OK,        5'd0, 1'b0, 5'd31);
    dir_table[5]  = cmd_row(OP_ALLOC,   5'd31, 1, STATUS_OK,        5'd0, 1'b0, 5'd31);
    dir_table[6]  = cmd_row(OP_ALLOC,   5'd0,  1, STATUS_OK,        5'd1, 1'b0, 5'd31);
    dir_table[7]  = cmd_row(OP_ALLOC,   5'd0,  1, STATUS_OK,        5'd2, 1'b0, 5'd31);
    dir_table[8]  = cmd_row(OpSpare6,   5'd31, 1, STATUS_OK,        5'd0, 1'b0, 5'd31);
    dir_table[9]  = cmd_row(OpSpare7,   5'd0,  1, STATUS_OK,        5'd0, 1'b0, 5'd31);
    dir_table[10] = cmd_row(OP_YIELD,   5'd0,  1, STATUS_NOT_ALLOC, 5'd0, 1'b0, 5'd31);
    dir_table[11] = cmd_row(OP_BLOCK,   5'd31, 1, STATUS_NOT_ALLOC, 5'd0, 1'b0, 5'd31);
    // Scheduling: wrap past slot 31, deadlock, re-pick of the running slot
    dir_table[12] = cmd_row(OP_BLOCK,   5'd1,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[13] = cmd_row(OP_YIELD,   5'd0,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[14] = cmd_row(OP_BLOCK,   5'd0,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[15] = cmd_row(OP_WAKE,    5'd1,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[16] = cmd_row(OP_YIELD,   5'd0,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[17] = cmd_row(OP_BLOCK,   5'd1,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[18] = cmd_row(OP_BLOCK,   5'd0,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[19] = cmd_row(OP_YIELD,   5'd0,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[20] = cmd_row(OP_RELEASE, 5'd2,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[21] = cmd_row(OP_YIELD,   5'd0,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[22] = cmd_row(OP_RELEASE, 5'd0,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[23] = cmd_row(OP_RELEASE, 5'd1,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);
    dir_table[24] = cmd_row(OP_ALLOC,   5'd0,  0, STATUS_OK, 5'd0, 1'b0, 5'd0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      issue(dir_table[i].req, dir_table[i].fixed, dir_table[i].res);
      if (i % 5 == 4) pause($urandom_range(1, 12));
    end
    drain_results();

    sent     = 0;
    phase_no = 0;
    while (sent < RandItems) begin
      // open with a fill phase of allocates, which can reach the full table early
      kind      = (phase_no == 0) ? MIX_FILL : traffic_e'($urandom_range(0, 3));
      phase_len = (kind == MIX_FILL) ? $urandom_range(20, 45) : $urandom_range(20, 60);
      gaps_on   = ($urandom_range(0, 2) != 0) && (sent + 200 < RandItems);
      for (int n = 0; n < phase_len && sent < RandItems; n++) begin
        if (kind == MIX_NOISE) begin
          cmd.op            = choose_op(kind);
          cmd.target_thread = 5'($urandom_range(0, ThreadSlots - 1));
        end else begin
          cmd.op            = choose_op(kind);
          cmd.target_thread = pick_slot();
        end
        issue(cmd, 1'b0, '0);
        sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 12));
      end
      if (gaps_on && $urandom_range(0, 3) == 0) drain_results();
      phase_no++;
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("round_robin_thread_slot_scheduler test passed");
    end else begin
      $display("round_robin_thread_slot_scheduler test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rrts_pkg.sv
rtl/core/rrts_slot_store.sv
rtl/core/rrts_seq.sv
rtl/core/round_robin_thread_slot_scheduler.sv
test/tb_round_robin_thread_slot_scheduler.sv
